// File: hw/rtl/mfd_pkg.sv
// Shared types, constants and helpers for the modulated feedback delay.
package mfd_pkg;

  localparam int unsigned BUF_DEPTH_DEF    = 4096;
  localparam int unsigned CHANNELS_DEF     = 2;
  localparam int unsigned SINE_ENTRIES_DEF = 256;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 20;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned OFS_W    = 21;

  // multiplier operand and product widths
  localparam int unsigned MA_W = 22;
  localparam int unsigned MB_W = 18;
  localparam int unsigned MP_W = MA_W + MB_W;

  // quarter-wave polynomial coefficients, Q15
  localparam logic [16:0] POLY_A = 17'd51472;
  localparam logic [16:0] POLY_B = 17'd21167;
  localparam logic [16:0] POLY_C = 17'd2463;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_DELAY_TIME    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_DELAY     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WET_MIX       = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FEEDBACK_GAIN = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PHASE_STEP    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MOD_DEPTH     = 3'd5;
  localparam logic [CFG_IW-1:0] REG_MOD_ENABLE    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_LFO_SHAPE     = 3'd7;

  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SQ, ST_C, ST_T1, ST_T2, ST_RES, ST_OFSM, ST_OFS,
    ST_DLY, ST_POS, ST_RD0, ST_RD1, ST_I0, ST_I1, ST_I2, ST_WR, ST_M1, ST_M2
  } mfd_state_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [MP_W:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > (MP_W+1)'(32767)) r = 16'sh7FFF;
    else if (v < -(MP_W+1)'(32768)) r = 16'sh8000;
    else r = v[SAMPLE_W-1:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/mfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module mfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/modulated_feedback_delay.sv
// Modulated fractional feedback delay: per-channel circular store, LFO, interpolated read.
// Each accepted item (one Q1.15 sample and its channel) yields one mixed output item.
// The delay store for all channels sits in one RAM of CHANNELS*BUF_DEPTH words; a
// sequencer drives one shared 22x18 multiplier and the RAM port. From acceptance to
// result an item passes the steps DLY, POS, RD0, RD1, I0, I1, I2, WR, M1 and M2; on
// channel 0 with modulation on, the quarter-wave sine polynomial and depth scaling
// add seven steps before them: five multiplier passes and two capture steps. The
// multiplier and the single RAM read port serve one item in flight at a time. The
// next item is taken in the idle step that follows once the result is registered.
// A finished item waits in the output register, and the next item can be accepted
// meanwhile; the following result then holds the sequencer in its last step until
// the waiting one is taken. After reset the store of CHANNELS*BUF_DEPTH words
// (8192 by default) is cleared one word a cycle; items wait, configuration writes
// are taken. BUF_DEPTH and SINE_ENTRIES must be powers of two. A delay of exactly
// BUF_DEPTH reads the oldest sample, the one about to be overwritten.
module modulated_feedback_delay
  import mfd_pkg::*;
#(
  parameter int unsigned BUF_DEPTH    = BUF_DEPTH_DEF,
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_channel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_we,
  input  logic [CFG_IW-1:0]          cfg_index,
  input  logic [TIME_W-1:0]          cfg_data
);

  localparam int unsigned BAW   = $clog2(BUF_DEPTH);
  localparam int unsigned MDEP  = CHANNELS * BUF_DEPTH;
  localparam int unsigned MAW   = $clog2(MDEP);
  localparam int unsigned CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SWB   = $clog2(SINE_ENTRIES);
  // delay and read position widths, signed
  localparam int unsigned DW    = ((BAW + 9) > 22 ? (BAW + 9) : 22) + 1;
  localparam int unsigned PW    = DW + 1;
  localparam logic [PHASE_W-1:0] QMASK = PHASE_W'(17'h0FFFF << (PHASE_W - SWB));
  localparam logic signed [PW-1:0] SPAN = PW'(BUF_DEPTH) <<< 8;

  // configuration
  logic [TIME_W-1:0]  delay_time_r, min_delay_r, mod_depth_r;
  logic [GAIN_W-1:0]  wet_mix_r, feedback_gain_r;
  logic [PHASE_W-1:0] phase_step_r;
  logic               mod_enable_r;
  logic [1:0]         lfo_shape_r;

  // sequencer and datapath state
  mfd_state_t state_r, state_nxt;
  logic [MAW:0]       clr_cnt_r;
  logic [BAW-1:0]     wp_r [CHANNELS];
  logic [PHASE_W-1:0] lfo_phase_r;
  logic signed [OFS_W-1:0] lfo_offset_r;
  logic signed [SAMPLE_W-1:0] x_r, s0_r, s1_r, dv_r, lfo_r;
  logic [CIW-1:0]     ch_r;
  logic [16:0]        z2_r;
  logic signed [DW-1:0] d_r;
  logic [BAW-1:0]     before_r, after_r;
  logic [7:0]         frac_r;
  logic signed [MP_W-1:0] prod_r, acc_r;
  logic               out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // shared multiplier operands
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  // RAM port
  logic               ram_we;
  logic [MAW-1:0]     ram_waddr, ram_raddr, ch_base;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  // sine evaluation helpers
  logic [PHASE_W-1:0] qa;
  logic [16:0]        z;
  logic [16:0]        t1, t2;
  logic [16:0]        sin_mag;
  logic signed [SAMPLE_W-1:0] sine_val, tri_val, lfo_nxt;
  logic signed [18:0] tri_raw;

  // delay and position
  logic signed [DW-1:0] d_sum, d_clamp;
  logic signed [PW-1:0] pos0, pos1;
  logic [GAIN_W-1:0]  mix, dry;
  logic signed [MP_W:0] fb_sum, mix_sum;
  logic signed [MP_W-1:0] interp_sum;
  logic               ch_in;
  logic               accept;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign ch_in    = (CHANNELS > 1) ? in_channel : 1'b0;
  assign ch_base  = MAW'(ch_r) << BAW;

  // sine: phase truncated to the table grid, quarter-wave polynomial
  assign qa      = lfo_phase_r & QMASK;
  assign z       = qa[14] ? ((17'd16384 - {3'b0, qa[13:0]}) << 1) : ({3'b0, qa[13:0]} << 1);
  assign t1      = POLY_B - 17'(prod_r >>> 15);
  assign t2      = POLY_A - 17'(prod_r >>> 15);
  assign sin_mag = (prod_r >>> 15) > MP_W'(32767) ? 17'd32767 : 17'(prod_r >>> 15);
  assign sine_val = qa[15] ? -SAMPLE_W'(sin_mag) : SAMPLE_W'(sin_mag);

  always_comb begin
    if (lfo_phase_r < 16'd16384) tri_raw = 19'(lfo_phase_r) <<< 1;
    else if (lfo_phase_r < 16'd49152) tri_raw = 19'sd65536 - (19'(lfo_phase_r) <<< 1);
    else tri_raw = (19'(lfo_phase_r) <<< 1) - 19'sd131072;
    if (tri_raw > 19'sd32767) tri_val = 16'sd32767;
    else if (tri_raw < -19'sd32767) tri_val = -16'sd32767;
    else tri_val = tri_raw[SAMPLE_W-1:0];
  end

  always_comb begin
    case (lfo_shape_r)
      SHAPE_TRIANGLE: lfo_nxt = tri_val;
      SHAPE_SQUARE:   lfo_nxt = (sine_val >= 0) ? 16'sd32767 : -16'sd32767;
      default:        lfo_nxt = sine_val;
    endcase
  end

  // delay clamp: lower bound first, upper bound wins
  always_comb begin
    d_sum = DW'($signed({1'b0, delay_time_r})) + DW'(lfo_offset_r);
    d_clamp = d_sum;
    if (d_clamp < DW'($signed({1'b0, min_delay_r}))) d_clamp = DW'($signed({1'b0, min_delay_r}));
    if (PW'(d_clamp) > SPAN) d_clamp = DW'(SPAN);
  end

  always_comb begin
    pos0 = (PW'($signed({1'b0, wp_r[ch_r]})) <<< 8) - PW'(d_r);
    if (pos0 < 0) pos0 = pos0 + SPAN;
    if (pos0 < 0) pos0 = '0;
    pos1 = pos0;
    if (pos1 >= SPAN) pos1 = pos1 - SPAN;
  end

  assign mix        = (wet_mix_r > 16'd32768) ? 16'd32768 : wet_mix_r;
  assign dry        = 16'd32768 - mix;
  assign interp_sum = acc_r + prod_r;
  assign fb_sum     = (MP_W+1)'(x_r) + (MP_W+1)'(prod_r >>> 15);
  assign mix_sum    = (MP_W+1)'((acc_r + prod_r) >>> 15);

  // sequencer: next state, multiplier operands, RAM control
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = ch_base | MAW'(wp_r[ch_r]);
    ram_wdata = SAMPLE_W'(sat16(fb_sum));
    ram_raddr = ch_base | MAW'(before_r);
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r[MAW-1:0];
        ram_wdata = '0;
        if (clr_cnt_r == (MAW+1)'(MDEP - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!ch_in && mod_enable_r) state_nxt = ST_SQ;
          else state_nxt = ST_DLY;
        end
      end
      ST_SQ: begin
        mul_a = MA_W'(z);
        mul_b = MB_W'(z);
        state_nxt = ST_C;
      end
      ST_C: begin
        mul_a = MA_W'(17'(prod_r >>> 15));
        mul_b = MB_W'(POLY_C);
        state_nxt = ST_T1;
      end
      ST_T1: begin
        mul_a = MA_W'(z2_r);
        mul_b = MB_W'(t1);
        state_nxt = ST_T2;
      end
      ST_T2: begin
        mul_a = MA_W'(z);
        mul_b = MB_W'(t2);
        state_nxt = ST_RES;
      end
      ST_RES:  state_nxt = ST_OFSM;
      ST_OFSM: begin
        mul_a = MA_W'(mod_depth_r);
        mul_b = MB_W'(lfo_r);
        state_nxt = ST_OFS;
      end
      ST_OFS:  state_nxt = ST_DLY;
      ST_DLY:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1: begin
        ram_raddr = ch_base | MAW'(after_r);
        state_nxt = ST_I0;
      end
      ST_I0: begin
        mul_a = MA_W'(s0_r);
        mul_b = MB_W'(10'd256 - 10'(frac_r));
        state_nxt = ST_I1;
      end
      ST_I1: begin
        mul_a = MA_W'(s1_r);
        mul_b = MB_W'(frac_r);
        state_nxt = ST_I2;
      end
      ST_I2: begin
        mul_a = MA_W'(feedback_gain_r);
        mul_b = MB_W'(SAMPLE_W'(interp_sum >>> 8));
        state_nxt = ST_WR;
      end
      ST_WR: begin
        ram_we = 1'b1;
        mul_a  = MA_W'(dry);
        mul_b  = MB_W'(x_r);
        state_nxt = ST_M1;
      end
      ST_M1, ST_M2: begin
        mul_a = MA_W'(mix);
        mul_b = MB_W'(dv_r);
        if (state_r == ST_M1) state_nxt = ST_M2;
        else if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      lfo_phase_r  <= '0;
      lfo_offset_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) wp_r[i] <= '0;
      delay_time_r    <= '0;
      min_delay_r     <= TIME_W'(12288);
      wet_mix_r       <= 16'd16384;
      feedback_gain_r <= '0;
      phase_step_r    <= '0;
      mod_depth_r     <= '0;
      mod_enable_r    <= 1'b0;
      lfo_shape_r     <= SHAPE_SINE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (accept && !ch_in && !mod_enable_r) lfo_offset_r <= '0;
      if (state_r == ST_RES) lfo_phase_r <= lfo_phase_r + phase_step_r;
      if (state_r == ST_OFS) lfo_offset_r <= prod_r[OFS_W+14:15];
      if (state_r == ST_WR) wp_r[ch_r] <= wp_r[ch_r] + 1'b1;
      if (state_r == ST_M2 && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DELAY_TIME:    delay_time_r    <= cfg_data;
          REG_MIN_DELAY:     min_delay_r     <= cfg_data;
          REG_WET_MIX:       wet_mix_r       <= cfg_data[GAIN_W-1:0];
          REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[GAIN_W-1:0];
          REG_PHASE_STEP:    phase_step_r    <= cfg_data[PHASE_W-1:0];
          REG_MOD_DEPTH:     mod_depth_r     <= cfg_data;
          REG_MOD_ENABLE:    mod_enable_r    <= cfg_data[0];
          REG_LFO_SHAPE:     lfo_shape_r     <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      x_r  <= in_sample_in;
      ch_r <= CIW'(ch_in);
    end
    case (state_r)
      ST_C:   z2_r  <= 17'(prod_r >>> 15);
      ST_RES: lfo_r <= lfo_nxt;
      ST_DLY: d_r   <= d_clamp;
      ST_POS: begin
        before_r <= pos1[BAW+7:8];
        after_r  <= pos1[BAW+7:8] + 1'b1;
        frac_r   <= pos1[7:0];
      end
      ST_RD1: s0_r  <= ram_rdata;
      ST_I0:  s1_r  <= ram_rdata;
      ST_I1:  acc_r <= prod_r;
      ST_I2:  dv_r  <= SAMPLE_W'(interp_sum >>> 8);
      ST_M1:  acc_r <= prod_r;
      ST_M2:  if (out_free) out_sample_r <= sat16(mix_sum);
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  mfd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MDEP)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef ASSERT_OFF
  // one item in flight: no acceptance in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("item accepted while another is in flight");

  // no items during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item taken during store clear");

  // store is written only by the clear pass or the write-back step
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_WR))
    else $error("unexpected store write");

  // a result appears only after the mix step
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_M2))
    else $error("result without mix step");
`endif

endmodule

// File: bench/modulated_feedback_delay_test.sv
// Self-checking testbench for the modulated feedback delay block.
module modulated_feedback_delay_test;
  import mfd_pkg::*;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned NCH   = 2;
  localparam int unsigned SINE_N = 256;
  localparam longint SPAN = longint'(DEPTH) * 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic in_channel = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [TIME_W-1:0] cfg_data = '0;

  modulated_feedback_delay u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_in(in_sample_in), .in_channel(in_channel),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12-unit clock period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, stores and LFO.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] p_delay, p_min, p_depth;
  logic [GAIN_W-1:0] p_wet, p_fb, p_step;
  logic p_mod_on;
  logic [1:0] p_shape;
  logic signed [SAMPLE_W-1:0] line_mem [NCH*DEPTH];
  int unsigned wr_ptr [NCH];
  logic [PHASE_W-1:0] phase;
  longint lfo_ofs;

  logic signed [SAMPLE_W-1:0] mixed_q[$];  // expected outputs, oldest first
  int fail_cnt = 0;
  int mism_cnt = 0;
  int got_cnt = 0;

  function automatic longint fshift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + ((longint'(1) << s) - 1)) >>> s);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // quarter-wave polynomial sine, Q15
  function automatic longint sin_q15(logic [15:0] a);
    logic [1:0] quad;
    longint r, z, z2, t, res;
    quad = a[15:14];
    r = a[13:0];
    z = quad[0] ? (16384 - r) * 2 : r * 2;
    z2 = (z * z) >>> 15;
    t = 21167 - ((z2 * 2463) >>> 15);
    t = 51472 - ((z2 * t) >>> 15);
    res = (z * t) >>> 15;
    if (res > 32767) res = 32767;
    return quad[1] ? -res : res;
  endfunction

  function automatic longint lfo_now();
    longint idx, p, tri_v;
    logic [15:0] qa;
    p = phase;
    idx = (p * SINE_N) >>> 16;
    qa = 16'((idx << 16) / SINE_N);
    case (p_shape)
      SHAPE_TRIANGLE: begin
        if (p < 16384) tri_v = 2 * p;
        else if (p < 49152) tri_v = 65536 - 2 * p;
        else tri_v = 2 * p - 131072;
        if (tri_v > 32767) tri_v = 32767;
        if (tri_v < -32767) tri_v = -32767;
        return tri_v;
      end
      SHAPE_SQUARE: return (sin_q15(qa) >= 0) ? 32767 : -32767;
      default: return sin_q15(qa);
    endcase
  endfunction

  function automatic void delay_reset();
    p_delay = 0; p_min = 12288; p_wet = 16384; p_fb = 0;
    p_step = 0; p_depth = 0; p_mod_on = 0; p_shape = SHAPE_SINE;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (wr_ptr[i]) wr_ptr[i] = 0;
    phase = '0;
    lfo_ofs = 0;
  endfunction

  // one sample through the delay line; returns the mixed output
  function automatic logic signed [SAMPLE_W-1:0] delay_step(
      logic signed [SAMPLE_W-1:0] smp, logic ch_bit);
    int unsigned ch, wp, b0, b1, base;
    longint x, d, pos, frac, dv, mix;
    x = smp;
    ch = ch_bit % NCH;
    base = ch * DEPTH;
    wp = wr_ptr[ch] % DEPTH;
    if (ch == 0) begin
      if (p_mod_on) begin
        lfo_ofs = fshift(longint'(p_depth) * lfo_now(), 15);
        phase = phase + p_step;
      end else begin
        lfo_ofs = 0;
      end
    end
    d = longint'(p_delay) + lfo_ofs;
    if (d < longint'(p_min)) d = p_min;
    if (d > SPAN) d = SPAN;   // upper bound wins over a crossed clamp
    pos = longint'(wp) * 256 - d;
    if (pos < 0) pos += SPAN;
    if (pos < 0) pos = 0;
    if (pos >= SPAN) pos -= SPAN;
    b0 = int'(pos >>> 8) % DEPTH;
    b1 = (b0 + 1) % DEPTH;
    frac = pos & 255;
    dv = fshift(longint'(line_mem[base+b0]) * (256 - frac)
                + longint'(line_mem[base+b1]) * frac, 8);
    line_mem[base+wp] = 16'(clip16(x + fshift(longint'(p_fb) * dv, 15)));
    mix = (p_wet > 32768) ? 32768 : longint'(p_wet);
    wr_ptr[ch] = (wp + 1) % DEPTH;
    return 16'(clip16(fshift((32768 - mix) * x + mix * dv, 15)));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [CFG_IW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= TIME_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DELAY_TIME:    p_delay = TIME_W'(val);
      REG_MIN_DELAY:     p_min = TIME_W'(val);
      REG_WET_MIX:       p_wet = GAIN_W'(val);
      REG_FEEDBACK_GAIN: p_fb = GAIN_W'(val);
      REG_PHASE_STEP:    p_step = GAIN_W'(val);
      REG_MOD_DEPTH:     p_depth = TIME_W'(val);
      REG_MOD_ENABLE:    p_mod_on = val[0];
      REG_LFO_SHAPE:     p_shape = val[1:0];
      default: ;
    endcase
  endtask

  // offer one item; the expectation is queued at acceptance.
  // valid drops before an idle gap, or in drain after the last item
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic ch,
                             bit has_fixed, logic signed [SAMPLE_W-1:0] fixed_val);
    logic signed [SAMPLE_W-1:0] pred;
    int unsigned gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_channel <= ch;
    do @(posedge clk); while (!in_ready);
    pred = delay_step(smp, ch);
    if (has_fixed && pred != fixed_val) begin
      fail_cnt++;
      mism_cnt++;
      if (mism_cnt <= 10)
        $display("table entry disagrees: expected %0d predicted %0d", fixed_val, pred);
    end
    mixed_q.push_back(pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);   // longest item path is channel 0 with modulation on
  endtask

  // result side: random stall per item, burst mode now and then
  initial begin
    int unsigned stall;
    forever begin
      stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted item against the oldest expectation
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      got_cnt++;
      if (mixed_q.size() == 0) begin
        fail_cnt++;
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected output %0d", out_sample_out);
      end else begin
        want = mixed_q.pop_front();
        if (out_sample_out !== want) begin
          fail_cnt++;
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("sample_out mismatch: expected %0d actual %0d", want, out_sample_out);
        end
      end
    end
  end

  // directed table: sample, channel, whether expected is fixed, expected value
  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic ch;
    bit fixed;
    logic signed [SAMPLE_W-1:0] want;
  } stim_row_t;

  stim_row_t plan [] = '{
    // fresh store, half wet: output is half of the input
    '{16'sh7FFF, 1'b0, 1'b1, 16'sd16383},
    '{16'sh8000, 1'b0, 1'b1, -16'sd16384},
    '{16'sh8000, 1'b1, 1'b1, -16'sd16384},
    '{16'sh7FFF, 1'b1, 1'b1, 16'sd16383},
    '{16'sd0,    1'b0, 1'b1, 16'sd0},
    '{16'sd1,    1'b1, 1'b1, 16'sd0},
    '{-16'sd1,   1'b0, 1'b1, -16'sd1},
    '{16'sh5555, 1'b0, 1'b0, 16'sd0},
    '{16'shAAAA, 1'b1, 1'b0, 16'sd0},
    '{16'sh1234, 1'b0, 1'b0, 16'sd0}
  };

  // random phase: random settings, at most one of them at its extreme, then a run of samples
  task automatic random_phase(int n);
    int unsigned pick;
    pick = $urandom_range(0, 5);
    cfg_write(REG_DELAY_TIME, (pick == 0) ? 20'hFFFFF : $urandom_range(0, 64 * 256));
    cfg_write(REG_MIN_DELAY, (pick == 1) ? 20'hFFFFF : $urandom_range(0, 8 * 256));
    cfg_write(REG_WET_MIX, (pick == 2) ? 16'hFFFF : $urandom_range(0, 32768));
    cfg_write(REG_FEEDBACK_GAIN, (pick == 3) ? 16'hFFFF : $urandom_range(0, 40000));
    cfg_write(REG_PHASE_STEP, $urandom_range(0, 65535));
    cfg_write(REG_MOD_DEPTH, (pick == 4) ? 20'hFFFFF : $urandom_range(0, 48 * 256));
    cfg_write(REG_MOD_ENABLE, ($urandom_range(0, 3) != 0));
    cfg_write(REG_LFO_SHAPE, $urandom_range(0, 3));
    repeat (n) send_sample(16'($urandom), 1'($urandom), 1'b0, 16'sd0);
    drain();
  endtask

  initial begin
    delay_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_sample(plan[i].smp, plan[i].ch, plan[i].fixed, plan[i].want);
    drain();

    // full-length delay, crossed clamp, wet and feedback above one, every LFO shape code
    cfg_write(REG_MIN_DELAY, 20'hFFFFF);
    cfg_write(REG_WET_MIX, 16'hFFFF);
    cfg_write(REG_FEEDBACK_GAIN, 16'hFFFF);
    repeat (4) send_sample(16'sh7FFF, 1'b0, 1'b0, 16'sd0);
    drain();
    cfg_write(REG_MIN_DELAY, 0);
    cfg_write(REG_DELAY_TIME, 0);
    cfg_write(REG_MOD_ENABLE, 1);
    cfg_write(REG_MOD_DEPTH, 20'hFFFFF);
    cfg_write(REG_PHASE_STEP, 16'hFFFF);
    for (int s = 0; s < 4; s++) begin
      cfg_write(REG_LFO_SHAPE, s);
      send_sample(16'sh4000, 1'b0, 1'b0, 16'sd0);
      send_sample(16'shC000, 1'b1, 1'b0, 16'sd0);
      drain();
    end

    for (int k = 0; k < 22; k++) random_phase(50);

    // back to reset-like values at the end, but with a fully dry mix
    cfg_write(REG_DELAY_TIME, 0);
    cfg_write(REG_MIN_DELAY, 12288);
    cfg_write(REG_WET_MIX, 0);
    cfg_write(REG_FEEDBACK_GAIN, 0);
    cfg_write(REG_PHASE_STEP, 0);
    cfg_write(REG_MOD_DEPTH, 0);
    cfg_write(REG_MOD_ENABLE, 0);
    cfg_write(REG_LFO_SHAPE, SHAPE_SINE);
    repeat (20) send_sample(16'($urandom), 1'($urandom), 1'b0, 16'sd0);
    drain();

    if (fail_cnt == 0 && mixed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog: store clear plus ~1200 items at worst-case gaps and stalls
  initial begin
    #6000000;
    $display("tb: failure");
    $finish;
  end

endmodule
